/* rtl/core/blt_pkg.sv */
`default_nettype none

package blt_pkg;

	// Fixed field widths of the channels
	localparam int BYTE_W       = 8;
	localparam int ROW_FIELD_W  = 6;
	localparam int EDGE_FIELD_W = 7;

	// Sequencer to scan unit
	typedef struct packed {
		logic start;
		logic seed;
		logic right_side;
	} scan_cmd_t;

	// Scan unit to sequencer
	typedef struct packed {
		logic idle;
		logic done;
	} scan_sts_t;

endpackage

`default_nettype wire

/* rtl/core/blt_chan_if.sv */
`default_nettype none

interface blt_in_if;
	import blt_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   pixel_byte;
	logic                frame_start;

	modport source (output valid, pixel_byte, frame_start, input ready);
	modport sink (input valid, pixel_byte, frame_start, output ready);
endinterface

interface blt_out_if;
	import blt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ROW_FIELD_W-1:0]  row_index;
	logic [EDGE_FIELD_W-1:0] left_edge;
	logic [EDGE_FIELD_W-1:0] right_edge;
	logic [EDGE_FIELD_W-1:0] center_column;
	logic                    last_row;

	modport source (output valid, row_index, left_edge, right_edge, center_column, last_row,
		input ready);
	modport sink (input valid, row_index, left_edge, right_edge, center_column, last_row,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/blt_frame_store.sv */
`default_nettype none

module blt_frame_store #(
	parameter int IMG_WIDTH  = 80,
	parameter int IMG_HEIGHT = 60
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           wr_en,
	input  wire logic [blt_pkg::BYTE_W-1:0]                     wr_data,
	input  wire logic                                           frame_start,
	output logic                                                frame_done,
	input  wire logic [$clog2((IMG_WIDTH*IMG_HEIGHT+7)/8)-1:0]  rd_addr,
	output logic [blt_pkg::BYTE_W-1:0]                          rd_data
);
	import blt_pkg::*;

	localparam int FRAME_BYTES = (IMG_WIDTH * IMG_HEIGHT + 7) / 8;
	localparam int AW          = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

	logic [BYTE_W-1:0] mem_q [FRAME_BYTES];
	logic [AW-1:0]     load_q;
	logic [AW-1:0]     wr_addr;

	// Restart the load address on a frame start beat
	assign wr_addr    = frame_start ? '0 : load_q;
	assign frame_done = wr_en && (wr_addr == LAST_ADDR);

	// Advance the load address, wrap after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (wr_en) begin
			load_q <= frame_done ? '0 : wr_addr + AW'(1);
		end
	end

	// Byte memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_q <= LAST_ADDR)
		else $error("load address beyond frame");

endmodule

`default_nettype wire

/* rtl/core/blt_edge_scan.sv */
`default_nettype none

module blt_edge_scan #(
	parameter int IMG_WIDTH  = 80,
	parameter int IMG_HEIGHT = 60
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire blt_pkg::scan_cmd_t                             cmd,
	input  wire logic signed [$clog2(IMG_WIDTH+2):0]            start_col,
	input  wire logic [$clog2(IMG_WIDTH*IMG_HEIGHT)-1:0]        row_base,
	output logic [$clog2((IMG_WIDTH*IMG_HEIGHT+7)/8)-1:0]       rd_addr,
	input  wire logic [blt_pkg::BYTE_W-1:0]                     rd_data,
	output blt_pkg::scan_sts_t                                  sts,
	output logic [$clog2(IMG_WIDTH+1)-1:0]                      edge_col
);
	import blt_pkg::*;

	localparam int CW = $clog2(IMG_WIDTH + 2) + 1;
	localparam int EW = $clog2(IMG_WIDTH + 1);
	localparam int IW = $clog2(IMG_WIDTH * IMG_HEIGHT);
	localparam int AW = $clog2((IMG_WIDTH * IMG_HEIGHT + 7) / 8);
	localparam logic signed [CW-1:0] ONE       = CW'(1);
	localparam logic signed [CW-1:0] MID_COL   = CW'(IMG_WIDTH / 2);
	localparam logic signed [CW-1:0] LAST_COL  = CW'(IMG_WIDTH - 1);
	localparam logic signed [CW-1:0] WIDTH_COL = CW'(IMG_WIDTH);

	typedef enum logic [3:0] {
		SC_IDLE   = 4'b0001,
		SC_PROBE  = 4'b0010,
		SC_DECIDE = 4'b0100,
		SC_RUN    = 4'b1000
	} sc_state_t;

	sc_state_t             state_q;
	logic signed [CW-1:0]  rc_q;
	logic                  seed_q, right_q;
	logic                  dir_right_q, kind_r_q, use_lower_q, minus1_q;
	logic                  rd_vld_s1;
	logic                  forced_s1;
	logic [2:0]            bitsel_s1;
	logic signed [CW-1:0]  col_s1;
	logic                  prev_pix_q, have_prev_q;
	logic                  done_q;
	logic [EW-1:0]         edge_q;

	logic                  forced_rd;
	logic [IW-1:0]         idx;
	logic                  pix;
	logic                  lo_pix, hi_pix;
	logic signed [CW-1:0]  lo_col, hi_col, y, res;
	logic                  out_of_range, match, stop;
	logic [EW-1:0]         res_clamped;
	logic signed [CW-1:0]  base_col, nxt_start;
	logic                  nxt_dir, nxt_kind_r, nxt_lower, nxt_minus1;

	// Read address of the column under probe; border and outside columns read black
	assign forced_rd = (rc_q <= 0) || (rc_q >= LAST_COL);
	assign idx       = row_base + IW'($unsigned(rc_q));
	assign rd_addr   = forced_rd ? '0 : AW'(idx >> 3);

	// Pixel of the column read last cycle, MSB first in its byte
	assign pix = forced_s1 | rd_data[~bitsel_s1];

	// Pair the new pixel with the one read before it
	always_comb begin
		lo_pix       = dir_right_q ? prev_pix_q : pix;
		hi_pix       = dir_right_q ? pix : prev_pix_q;
		hi_col       = dir_right_q ? col_s1 : col_s1 + ONE;
		lo_col       = dir_right_q ? col_s1 - ONE : col_s1;
		y            = use_lower_q ? lo_col : hi_col;
		out_of_range = dir_right_q ? (y > LAST_COL) : (y < 0);
		match        = kind_r_q ? (!lo_pix && hi_pix) : (lo_pix && !hi_pix);
		stop         = rd_vld_s1 && have_prev_q && (out_of_range || match);
		res          = minus1_q ? y - ONE : y;
		if (res < 0) begin
			res_clamped = '0;
		end else if (res > WIDTH_COL) begin
			res_clamped = EW'(IMG_WIDTH);
		end else begin
			res_clamped = EW'(res);
		end
	end

	// Pick direction and pattern from the pixel at the start column, or from the side alone for seed rows
	always_comb begin
		base_col = seed_q ? MID_COL : rc_q;
		if (seed_q) begin
			nxt_dir    = right_q;
			nxt_kind_r = right_q;
			nxt_lower  = !right_q;
			nxt_minus1 = 1'b0;
		end else if (right_q) begin
			nxt_dir    = !pix;
			nxt_kind_r = 1'b1;
			nxt_lower  = 1'b0;
			nxt_minus1 = 1'b0;
		end else begin
			nxt_dir    = pix;
			nxt_kind_r = 1'b0;
			nxt_lower  = 1'b0;
			nxt_minus1 = !pix;
		end
		if (nxt_dir) begin
			nxt_start = base_col - ONE;
		end else if (nxt_lower) begin
			nxt_start = base_col + ONE;
		end else begin
			nxt_start = base_col;
		end
	end

	// Control: sequence probe, decide and run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SC_IDLE;
			rd_vld_s1   <= 1'b0;
			have_prev_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == SC_RUN) && !stop;
			done_q    <= (state_q == SC_RUN) && stop;
			unique case (state_q)
				SC_IDLE: begin
					if (cmd.start) begin
						state_q <= SC_PROBE;
					end
				end
				SC_PROBE: begin
					state_q <= SC_DECIDE;
				end
				SC_DECIDE: begin
					have_prev_q <= 1'b0;
					state_q     <= SC_RUN;
				end
				SC_RUN: begin
					if (rd_vld_s1) begin
						have_prev_q <= 1'b1;
					end
					if (stop) begin
						state_q <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	// Datapath: column walk, read tracking, result
	always_ff @(posedge clk) begin
		col_s1    <= rc_q;
		forced_s1 <= forced_rd;
		bitsel_s1 <= idx[2:0];
		if (state_q == SC_IDLE && cmd.start) begin
			rc_q    <= start_col;
			seed_q  <= cmd.seed;
			right_q <= cmd.right_side;
		end
		if (state_q == SC_DECIDE) begin
			rc_q        <= nxt_start;
			dir_right_q <= nxt_dir;
			kind_r_q    <= nxt_kind_r;
			use_lower_q <= nxt_lower;
			minus1_q    <= nxt_minus1;
		end
		if (state_q == SC_RUN) begin
			rc_q <= dir_right_q ? rc_q + ONE : rc_q - ONE;
			if (rd_vld_s1) begin
				prev_pix_q <= pix;
			end
			if (stop) begin
				edge_q <= res_clamped;
			end
		end
	end

	assign sts.idle = (state_q == SC_IDLE);
	assign sts.done = done_q;
	assign edge_col = edge_q;

	a_edge_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (edge_q <= EW'(IMG_WIDTH)))
		else $error("edge beyond image width");

	a_run_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == SC_IDLE) && !rd_vld_s1)
		else $error("scan still running after its result");

endmodule

`default_nettype wire

/* rtl/core/binary_lane_edge_tracker.sv */
`default_nettype none

// Loading: one byte beat accepted per cycle while valid, until the last byte of the frame.
// Tracking: each row runs two scans, right side then left side, each walking the
// columns one pixel per cycle through the frame memory read port, then an emit
// step that waits for a free output register; the frame takes IMG_HEIGHT rows.
// Input ready is low while tracking; results leave through an output register.
// Reset clears control and edge history; frame memory contents are undefined.

module binary_lane_edge_tracker #(
	parameter int IMG_WIDTH  = 80,
	parameter int IMG_HEIGHT = 60,
	parameter int SEED_ROWS  = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	blt_in_if.sink    pixels,
	blt_out_if.source edges
);
	import blt_pkg::*;

	localparam int CW = $clog2(IMG_WIDTH + 2) + 1;
	localparam int EW = $clog2(IMG_WIDTH + 1);
	localparam int IW = $clog2(IMG_WIDTH * IMG_HEIGHT);
	localparam int AW = $clog2((IMG_WIDTH * IMG_HEIGHT + 7) / 8);
	localparam int RW = $clog2(IMG_HEIGHT);
	localparam logic [RW-1:0] TOP_ROW    = RW'(IMG_HEIGHT - 1);
	localparam logic [RW-1:0] SEED_FIRST = RW'(IMG_HEIGHT - SEED_ROWS);
	localparam logic [IW-1:0] TOP_BASE   = IW'((IMG_HEIGHT - 1) * IMG_WIDTH);
	localparam logic [IW-1:0] ROW_STEP   = IW'(IMG_WIDTH);

	typedef enum logic [3:0] {
		T_LOAD  = 4'b0001,
		T_RIGHT = 4'b0010,
		T_LEFT  = 4'b0100,
		T_EMIT  = 4'b1000
	} trk_state_t;

	trk_state_t            state_q;
	logic                  start_q;
	logic [RW-1:0]         row_q;
	logic [IW-1:0]         row_base_q;
	logic [EW-1:0]         prev_l_q, prev_r_q;
	logic                  out_vld_q;
	logic [ROW_FIELD_W-1:0]  row_index_q;
	logic [EDGE_FIELD_W-1:0] left_q, right_q, center_q;
	logic                  last_q;

	logic                  wr_en;
	logic                  frame_done;
	logic [AW-1:0]         rd_addr;
	logic [BYTE_W-1:0]     rd_data;
	scan_cmd_t             cmd;
	scan_sts_t             sts;
	logic [EW-1:0]         edge_col;
	logic signed [CW-1:0]  start_col;
	logic                  out_free;
	logic                  emit;
	logic [EW:0]           edge_sum;

	assign pixels.ready = (state_q == T_LOAD);
	assign wr_en        = pixels.valid && pixels.ready;

	blt_frame_store #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_data     (pixels.pixel_byte),
		.frame_start (pixels.frame_start),
		.frame_done  (frame_done),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	// Launch the scan for the current side of the current row
	assign cmd.start      = start_q;
	assign cmd.seed       = (row_q >= SEED_FIRST);
	assign cmd.right_side = (state_q == T_RIGHT);
	assign start_col      = (state_q == T_RIGHT) ? CW'(prev_r_q) : CW'(prev_l_q);

	blt_edge_scan #(
		.IMG_WIDTH  (IMG_WIDTH),
		.IMG_HEIGHT (IMG_HEIGHT)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.start_col (start_col),
		.row_base  (row_base_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.sts       (sts),
		.edge_col  (edge_col)
	);

	assign out_free = !out_vld_q || edges.ready;
	assign emit     = (state_q == T_EMIT) && out_free;
	assign edge_sum = {1'b0, prev_l_q} + {1'b0, prev_r_q};

	// Row sequencer: highest-index row first, down to row 0, right scan then left scan, then emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_LOAD;
			start_q    <= 1'b0;
			row_q      <= '0;
			row_base_q <= '0;
			prev_l_q   <= '0;
			prev_r_q   <= '0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				T_LOAD: begin
					if (frame_done) begin
						row_q      <= TOP_ROW;
						row_base_q <= TOP_BASE;
						start_q    <= 1'b1;
						state_q    <= T_RIGHT;
					end
				end
				T_RIGHT: begin
					if (sts.done) begin
						prev_r_q <= edge_col;
						start_q  <= 1'b1;
						state_q  <= T_LEFT;
					end
				end
				T_LEFT: begin
					if (sts.done) begin
						prev_l_q <= edge_col;
						state_q  <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (out_free) begin
						if (row_q == '0) begin
							state_q <= T_LOAD;
						end else begin
							row_q      <= row_q - RW'(1);
							row_base_q <= row_base_q - ROW_STEP;
							start_q    <= 1'b1;
							state_q    <= T_RIGHT;
						end
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

	// Output register: hold the row result until its beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (edges.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_index_q <= ROW_FIELD_W'(row_q);
			left_q      <= EDGE_FIELD_W'(prev_l_q);
			right_q     <= EDGE_FIELD_W'(prev_r_q);
			center_q    <= EDGE_FIELD_W'(edge_sum >> 1);
			last_q      <= (row_q == '0);
		end
	end

	assign edges.valid         = out_vld_q;
	assign edges.row_index     = row_index_q;
	assign edges.left_edge     = left_q;
	assign edges.right_edge    = right_q;
	assign edges.center_column = center_q;
	assign edges.last_row      = last_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> sts.idle)
		else $error("scan launched while busy");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == T_RIGHT || state_q == T_LEFT))
		else $error("scan result outside a scan state");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> sts.idle && !start_q)
		else $error("byte accepted during tracking");

endmodule

`default_nettype wire
